// File: sv/rps_pkg.sv
// Shared types and codes for the rectification process sequencer.
package rps_pkg;

  typedef enum logic [1:0] {
    MODE_TICK,
    MODE_START,
    MODE_CONTINUE,
    MODE_RETURN
  } mode_t;

  typedef enum logic [2:0] {
    PH_OFF,
    PH_WARM,
    PH_SELF,
    PH_WSELF,
    PH_HEAD,
    PH_WHEAD,
    PH_BODY
  } phase_t;

  typedef enum logic [2:0] {
    END_NONE,
    END_FAULT,
    END_MANUAL,
    END_TEMP,
    END_LEVEL,
    END_FLOOD,
    END_NOHEAD,
    END_NOSELF
  } halt_cause_t;

  typedef enum logic [2:0] {
    CFG_HEAD_POWER,
    CFG_HEAD_VALVE,
    CFG_WORK_POWER,
    CFG_WORK_VALVE,
    CFG_WARMUP_END_TEMP,
    CFG_SELF_RUN_MINUTES,
    CFG_OUTLET_MAX_TEMP,
    CFG_OUTLET_CRITICAL_TEMP
  } cfg_index_t;

  localparam int unsigned CfgIndexWidth = 3;
  localparam int unsigned CfgDataWidth  = 10;

  typedef struct packed {
    logic [6:0] head_power;
    logic [9:0] head_valve;
    logic [6:0] work_power;
    logic [9:0] work_valve;
    logic [6:0] warmup_end_temp;
    logic [6:0] self_run_minutes;
    logic [9:0] outlet_max_temp;
    logic [9:0] outlet_critical_temp;
  } rps_cfg_t;

  typedef struct packed {
    phase_t      phase;
    logic [6:0]  power_level;
    logic        heater_enabled;
    logic [9:0]  valve_level;
    halt_cause_t finish_cause;
    logic [11:0] body_stop_temp;
    logic        stop_learned;
    logic [1:0]  overtemp_count;
    logic        skip_heads;
    logic        level_arm;
    logic        flood_arm;
  } rps_state_t;

  typedef struct packed {
    mode_t       mode;
    logic [11:0] column_temp;
    logic [11:0] outlet_temp;
    logic        alarm1_fired;
    logic        alarm2_fired;
    logic        level_alarm;
    logic        flood_alarm;
    logic        heads_already_taken;
  } rps_item_t;

  typedef struct packed {
    logic [1:0] alarm1_request;
    logic [6:0] alarm2_request;
  } rps_req_t;

endpackage

// File: sv/rps_cfg_regs.sv
// Configuration register file of the rectification process sequencer.
module rps_cfg_regs
  import rps_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_we,
  input  logic [CfgIndexWidth-1:0] cfg_index,
  input  logic [CfgDataWidth-1:0]  cfg_data,
  output rps_cfg_t                 cfg
);

  rps_cfg_t cfg_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_q.head_power           <= 7'd40;
      cfg_q.head_valve           <= 10'd300;
      cfg_q.work_power           <= 7'd60;
      cfg_q.work_valve           <= 10'd400;
      cfg_q.warmup_end_temp      <= 7'd70;
      cfg_q.self_run_minutes     <= 7'd30;
      cfg_q.outlet_max_temp      <= 10'd450;
      cfg_q.outlet_critical_temp <= 10'd600;
    end else if (cfg_we) begin
      case (cfg_index_t'(cfg_index))
        CFG_HEAD_POWER:           cfg_q.head_power           <= cfg_data[6:0];
        CFG_HEAD_VALVE:           cfg_q.head_valve           <= cfg_data;
        CFG_WORK_POWER:           cfg_q.work_power           <= cfg_data[6:0];
        CFG_WORK_VALVE:           cfg_q.work_valve           <= cfg_data;
        CFG_WARMUP_END_TEMP:      cfg_q.warmup_end_temp      <= cfg_data[6:0];
        CFG_SELF_RUN_MINUTES:     cfg_q.self_run_minutes     <= cfg_data[6:0];
        CFG_OUTLET_MAX_TEMP:      cfg_q.outlet_max_temp      <= cfg_data;
        CFG_OUTLET_CRITICAL_TEMP: cfg_q.outlet_critical_temp <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  assign cfg = cfg_q;

endmodule

// File: sv/rps_step.sv
// Next-state and timer-request logic for one item of the sequencer.
module rps_step
  import rps_pkg::*;
(
  input  rps_cfg_t   cfg,
  input  rps_state_t st,
  input  rps_item_t  item,
  output rps_state_t st_next,
  output rps_req_t   req
);

  function automatic rps_state_t halt_run(rps_state_t s, halt_cause_t why);
    rps_state_t r;
    r                = s;
    r.phase          = PH_OFF;
    r.finish_cause   = why;
    r.power_level    = '0;
    r.heater_enabled = 1'b0;
    r.valve_level    = '0;
    r.flood_arm      = 1'b0;
    r.level_arm      = 1'b0;
    return r;
  endfunction

  function automatic logic [11:0] sat12(logic signed [12:0] v);
    logic [11:0] r;
    if (v > 13'sd2047) begin
      r = 12'h7ff;
    end else if (v < -13'sd2048) begin
      r = 12'h800;
    end else begin
      r = v[11:0];
    end
    return r;
  endfunction

  function automatic logic [6:0] clamp_pow(logic [6:0] v);
    return (v > 7'd100) ? 7'd100 : v;
  endfunction

  function automatic logic [9:0] clamp_valve(logic [9:0] v);
    return (v > 10'd1000) ? 10'd1000 : v;
  endfunction

  always_comb begin : step_logic
    rps_state_t         n;
    rps_req_t           r;
    logic signed [12:0] col;
    logic signed [12:0] outl;
    logic signed [12:0] stop13;
    logic [10:0]        warm_tenths;
    logic [10:0]        valve_up;

    n           = st;
    r           = '0;
    col         = {item.column_temp[11], item.column_temp};
    outl        = {item.outlet_temp[11], item.outlet_temp};
    warm_tenths = 11'(cfg.warmup_end_temp) * 11'd10;
    stop13      = '0;
    valve_up    = '0;

    case (item.mode)
      MODE_START: begin
        if (st.phase == PH_OFF) begin
          n.phase          = PH_WARM;
          n.finish_cause   = END_NONE;
          n.power_level    = 7'd98;
          n.heater_enabled = 1'b1;
          n.flood_arm      = 1'b1;
          n.overtemp_count = '0;
          n.stop_learned   = 1'b0;
          n.skip_heads     = item.heads_already_taken;
        end else begin
          n = halt_run(n, END_MANUAL);
        end
      end
      MODE_CONTINUE: begin
        if (st.phase == PH_WSELF) begin
          n.level_arm = 1'b1;
          n.phase     = PH_HEAD;
        end else if (st.phase == PH_WHEAD) begin
          n.power_level    = clamp_pow(cfg.work_power);
          n.valve_level    = clamp_valve(cfg.work_valve);
          n.level_arm      = 1'b0;
          n.body_stop_temp = sat12(col + 13'sd15);
          r.alarm2_request = 7'd40;
          n.phase          = PH_BODY;
        end
      end
      MODE_RETURN: begin
        if (st.phase != PH_OFF) begin
          n = halt_run(n, END_MANUAL);
        end
      end
      default: begin
        if (st.phase != PH_OFF) begin
          case (st.phase)
            PH_WARM: begin
              if (col > $signed({2'b00, warm_tenths})) begin
                n.power_level    = clamp_pow(cfg.head_power);
                n.valve_level    = clamp_valve(cfg.head_valve);
                n.phase          = PH_SELF;
                r.alarm2_request = cfg.self_run_minutes;
                r.alarm1_request = 2'd3;
              end
            end
            PH_SELF: begin
              if (item.alarm2_fired) begin
                n.phase          = st.skip_heads ? PH_WHEAD : PH_WSELF;
                r.alarm2_request = 7'd10;
              end
            end
            PH_WSELF: begin
              if (item.alarm2_fired) begin
                n = halt_run(n, END_NOSELF);
              end
            end
            PH_HEAD: begin
              if (st.level_arm && item.level_alarm) begin
                n.phase          = PH_WHEAD;
                r.alarm2_request = 7'd10;
              end
            end
            PH_WHEAD: begin
              if (item.alarm2_fired) begin
                n = halt_run(n, END_NOHEAD);
              end
            end
            PH_BODY: begin
              if (!st.stop_learned && item.alarm2_fired) begin
                n.body_stop_temp = sat12(col + 13'sd2);
                n.stop_learned   = 1'b1;
              end
              stop13 = {n.body_stop_temp[11], n.body_stop_temp};
              if (col > stop13) begin
                n = halt_run(n, END_TEMP);
              end
            end
            default: begin
            end
          endcase

          // An outlet above its maximum backs the heater off and opens the valve.
          if (item.alarm1_fired) begin
            if (outl > $signed({3'b000, cfg.outlet_max_temp})) begin
              n.power_level = (n.power_level < 7'd5) ? 7'd0 : n.power_level - 7'd5;
              valve_up      = {1'b0, n.valve_level} + 11'd5;
              n.valve_level = (valve_up > 11'd1000) ? 10'd1000 : valve_up[9:0];
              if (n.overtemp_count != 2'd3) begin
                n.overtemp_count = n.overtemp_count + 2'd1;
              end
              if (n.overtemp_count == 2'd3) begin
                n = halt_run(n, END_FAULT);
              end
            end else begin
              n.overtemp_count = '0;
            end
            r.alarm1_request = 2'd3;
          end
          if (outl > $signed({3'b000, cfg.outlet_critical_temp})) begin
            n = halt_run(n, END_FAULT);
          end
          if (n.flood_arm && item.flood_alarm) begin
            n = halt_run(n, END_FLOOD);
          end
        end
      end
    endcase

    st_next = n;
    req     = r;
  end

endmodule

// File: sv/rectification_process_sequencer_unit.sv
// Top level of the rectification process sequencer with its stream ports.
// An item waits in the input register; its result is then registered for m_tdata.
// Throughput: one item per cycle with m_tready high (single input and result register).
// An empty input register takes a new item while a finished result waits downstream.
// Reset (rst, synchronous, active high) sets the phase to off, clears all
// run state and loads the configuration registers with their defaults.
module rectification_process_sequencer_unit
  import rps_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     s_tvalid,
  output logic                     s_tready,
  // column_temp[11:0], outlet_temp[23:12], alarm1_fired[24], alarm2_fired[25],
  // level_alarm[26], flood_alarm[27], heads_already_taken[28], zero[31:29]
  input  logic [31:0]              s_tdata,
  // mode[1:0]
  input  logic [1:0]               s_tuser,
  output logic                     m_tvalid,
  input  logic                     m_tready,
  // process_state[2:0], heater_on[3], heater_power[10:4], valve_opening[20:11],
  // halt_cause[23:21], stop_temp[35:24], alarm1_request[37:36],
  // alarm2_request[44:38], level_armed[45], flood_armed[46], zero[47]
  output logic [47:0]              m_tdata,
  input  logic                     cfg_we,
  input  logic [CfgIndexWidth-1:0] cfg_index,
  input  logic [CfgDataWidth-1:0]  cfg_data
);

  rps_cfg_t   cfg;
  rps_state_t st;
  rps_state_t st_next;
  rps_req_t   req;
  rps_item_t  in_item;
  logic       in_valid;
  logic       out_valid;
  logic [47:0] out_data;
  logic       advance;

  rps_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  rps_step u_step (
    .cfg     (cfg),
    .st      (st),
    .item    (in_item),
    .st_next (st_next),
    .req     (req)
  );

  // The held item moves on when the result register is empty or being emptied.
  assign advance  = in_valid && (!out_valid || m_tready);
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_item.mode                <= mode_t'(s_tuser);
      in_item.column_temp         <= s_tdata[11:0];
      in_item.outlet_temp         <= s_tdata[23:12];
      in_item.alarm1_fired        <= s_tdata[24];
      in_item.alarm2_fired        <= s_tdata[25];
      in_item.level_alarm         <= s_tdata[26];
      in_item.flood_alarm         <= s_tdata[27];
      in_item.heads_already_taken <= s_tdata[28];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '0;
    end else if (advance) begin
      st <= st_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data <= {1'b0, st_next.flood_arm, st_next.level_arm, req.alarm2_request,
                   req.alarm1_request, st_next.body_stop_temp, st_next.finish_cause,
                   st_next.valve_level, st_next.power_level, st_next.heater_enabled,
                   st_next.phase};
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = out_data;

endmodule

// File: sv/rps_checker.sv
// Port-level checks for the rectification process sequencer, bound to its top level.
module rps_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [47:0] m_tdata
);

  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid straight after reset");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result changed");

  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && !m_tvalid |=> ##1 m_tvalid)
    else $error("accepted item produced no result");

  a_ranges: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[2:0] != 3'd7) && (m_tdata[10:4] <= 7'd100)
                 && (m_tdata[20:11] <= 10'd1000))
    else $error("result field out of range");

  a_end_means_off: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tdata[23:21] != 3'd0) |-> (m_tdata[2:0] == 3'd0) && !m_tdata[3]
                                           && (m_tdata[10:4] == 7'd0))
    else $error("end reason set while the run is active");

endmodule

bind rectification_process_sequencer_unit rps_checker u_rps_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

// File: test/tb_rectification_process_sequencer_unit.sv
// Self-checking testbench for the rectification process sequencer stream unit.
module tb_rectification_process_sequencer_unit;
  import rps_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int WarmupPower    = 98;
  localparam int PowerCeiling   = 100;
  localparam int ValveCeiling   = 1000;
  localparam int OvertempStep   = 5;
  localparam int OvertempLimit  = 3;
  localparam int CheckMinutes   = 3;
  localparam int WaitMinutes    = 10;
  localparam int BodyMinutes    = 40;
  localparam int EntryOffset    = 15;
  localparam int LearnOffset    = 2;
  localparam int ItemsPerPhase  = 150;
  localparam int RandomPhases   = 6;
  localparam int HoldOffCycles  = 80;

  typedef struct packed {
    phase_t      process_state;
    logic        heater_on;
    logic [6:0]  heater_power;
    logic [9:0]  valve_opening;
    halt_cause_t halt_cause;
    logic [11:0] stop_temp;
    logic [1:0]  alarm1_request;
    logic [6:0]  alarm2_request;
    logic        level_armed;
    logic        flood_armed;
  } status_t;

  typedef struct {
    rps_item_t item;
    bit        fixed;
    status_t   want;
  } script_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;
  logic [1:0]  s_tuser = MODE_TICK;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [47:0] m_tdata;
  logic        cfg_we = 1'b0;
  cfg_index_t  cfg_index = CFG_HEAD_POWER;
  logic [9:0]  cfg_data = '0;

  // Register copy and run state of the still, starting from their reset values.
  int          cfg_val [8] = '{40, 300, 60, 400, 70, 30, 450, 600};
  int unsigned next_cfg [8];
  phase_t      st_phase = PH_OFF;
  halt_cause_t st_cause = END_NONE;
  int          st_power = 0;
  int          st_valve = 0;
  int          st_stop_temp = 0;
  int          st_overtemp = 0;
  bit          st_heat = 1'b0;
  bit          st_learned = 1'b0;
  bit          st_skip = 1'b0;
  bit          st_level_arm = 1'b0;
  bit          st_flood_arm = 1'b0;

  status_t     awaited_status [$];
  script_row_t script [27];
  int          mismatches = 0;
  bit          calm = 1'b0;
  bit          squeeze = 1'b0;

  rectification_process_sequencer_unit DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always #1ns clk = ~clk;

  function automatic int clip(int v, int hi);
    if (v < 0) return 0;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic int sat12(int v);
    if (v > 2047) return 2047;
    if (v < -2048) return -2048;
    return v;
  endfunction

  function automatic void shut_down(halt_cause_t why);
    st_phase = PH_OFF;
    st_cause = why;
    st_power = 0;
    st_heat = 1'b0;
    st_valve = 0;
    st_flood_arm = 1'b0;
    st_level_arm = 1'b0;
  endfunction

  // Moves the still on by one item and returns the status it should report.
  function automatic status_t advance_still(rps_item_t it);
    int         col;
    int         outl;
    logic [1:0] req1;
    logic [6:0] req2;
    status_t    s;
    col = $signed(it.column_temp);
    outl = $signed(it.outlet_temp);
    req1 = '0;
    req2 = '0;
    case (it.mode)
      MODE_START: begin
        if (st_phase == PH_OFF) begin
          st_phase = PH_WARM;
          st_cause = END_NONE;
          st_power = WarmupPower;
          st_heat = 1'b1;
          st_flood_arm = 1'b1;
          st_overtemp = 0;
          st_learned = 1'b0;
          st_skip = it.heads_already_taken;
        end else begin
          shut_down(END_MANUAL);
        end
      end
      MODE_CONTINUE: begin
        if (st_phase == PH_WSELF) begin
          st_level_arm = 1'b1;
          st_phase = PH_HEAD;
        end else if (st_phase == PH_WHEAD) begin
          st_power = clip(cfg_val[CFG_WORK_POWER], PowerCeiling);
          st_valve = clip(cfg_val[CFG_WORK_VALVE], ValveCeiling);
          st_level_arm = 1'b0;
          st_stop_temp = sat12(col + EntryOffset);
          req2 = 7'(BodyMinutes);
          st_phase = PH_BODY;
        end
      end
      MODE_RETURN: begin
        if (st_phase != PH_OFF) shut_down(END_MANUAL);
      end
      default: begin
        if (st_phase != PH_OFF) begin
          case (st_phase)
            PH_WARM: begin
              if (col > cfg_val[CFG_WARMUP_END_TEMP] * 10) begin
                st_power = clip(cfg_val[CFG_HEAD_POWER], PowerCeiling);
                st_valve = clip(cfg_val[CFG_HEAD_VALVE], ValveCeiling);
                st_phase = PH_SELF;
                req2 = 7'(cfg_val[CFG_SELF_RUN_MINUTES]);
                req1 = 2'(CheckMinutes);
              end
            end
            PH_SELF: begin
              if (it.alarm2_fired) begin
                st_phase = st_skip ? PH_WHEAD : PH_WSELF;
                req2 = 7'(WaitMinutes);
              end
            end
            PH_WSELF: if (it.alarm2_fired) shut_down(END_NOSELF);
            PH_HEAD: begin
              if (st_level_arm && it.level_alarm) begin
                st_phase = PH_WHEAD;
                req2 = 7'(WaitMinutes);
              end
            end
            PH_WHEAD: if (it.alarm2_fired) shut_down(END_NOHEAD);
            PH_BODY: begin
              if (!st_learned && it.alarm2_fired) begin
                st_stop_temp = sat12(col + LearnOffset);
                st_learned = 1'b1;
              end
              if (col > st_stop_temp) shut_down(END_TEMP);
            end
            default: ;
          endcase
          // The remaining checks still run after a stop earlier in the same tick.
          if (it.alarm1_fired) begin
            if (outl > cfg_val[CFG_OUTLET_MAX_TEMP]) begin
              st_power = clip(st_power - OvertempStep, PowerCeiling);
              st_valve = clip(st_valve + OvertempStep, ValveCeiling);
              if (st_overtemp < OvertempLimit) st_overtemp++;
              if (st_overtemp >= OvertempLimit) shut_down(END_FAULT);
            end else begin
              st_overtemp = 0;
            end
            req1 = 2'(CheckMinutes);
          end
          if (outl > cfg_val[CFG_OUTLET_CRITICAL_TEMP]) shut_down(END_FAULT);
          if (st_flood_arm && it.flood_alarm) shut_down(END_FLOOD);
        end
      end
    endcase
    s.process_state = st_phase;
    s.heater_on = st_heat;
    s.heater_power = 7'(st_power);
    s.valve_opening = 10'(st_valve);
    s.halt_cause = st_cause;
    s.stop_temp = 12'(st_stop_temp);
    s.alarm1_request = req1;
    s.alarm2_request = req2;
    s.level_armed = st_level_arm;
    s.flood_armed = st_flood_arm;
    return s;
  endfunction

  function automatic rps_item_t mk_item(mode_t m, int col, int outl, bit a1, bit a2,
                                        bit lvl, bit fld, bit hd);
    rps_item_t it;
    it.mode = m;
    it.column_temp = col[11:0];
    it.outlet_temp = outl[11:0];
    it.alarm1_fired = a1;
    it.alarm2_fired = a2;
    it.level_alarm = lvl;
    it.flood_alarm = fld;
    it.heads_already_taken = hd;
    return it;
  endfunction

  function automatic status_t mk_status(phase_t ph, bit heat, int pwr, int vlv,
                                        halt_cause_t why, int stp, int r1, int r2,
                                        bit la, bit fa);
    status_t s;
    s.process_state = ph;
    s.heater_on = heat;
    s.heater_power = 7'(pwr);
    s.valve_opening = 10'(vlv);
    s.halt_cause = why;
    s.stop_temp = 12'(stp);
    s.alarm1_request = 2'(r1);
    s.alarm2_request = 7'(r2);
    s.level_armed = la;
    s.flood_armed = fa;
    return s;
  endfunction

  // Mostly items that suit the current phase, so that runs reach body collection.
  function automatic rps_item_t draw_item();
    rps_item_t   it;
    logic [63:0] raw;
    int          col;
    int          outl;
    int          roll;
    int          a2_pct;
    mode_t       m;
    raw = {$urandom, $urandom};
    if ($urandom_range(99) < 8) begin
      it = raw[$bits(rps_item_t)-1:0];
      return it;
    end
    roll = $urandom_range(99);
    m = MODE_TICK;
    if (st_phase == PH_OFF) begin
      if (roll < 65) m = MODE_START;
      else if (roll < 70) m = MODE_RETURN;
      else if (roll < 75) m = MODE_CONTINUE;
    end else if (st_phase == PH_WSELF || st_phase == PH_WHEAD) begin
      if (roll < 35) m = MODE_CONTINUE;
      else if (roll < 37) m = MODE_START;
      else if (roll < 39) m = MODE_RETURN;
    end else begin
      if (roll < 2) m = MODE_START;
      else if (roll < 4) m = MODE_RETURN;
      else if (roll < 7) m = MODE_CONTINUE;
    end
    if (st_phase == PH_WARM) begin
      col = cfg_val[CFG_WARMUP_END_TEMP] * 10 + int'($urandom_range(0, 50)) - 35;
    end else if (st_phase == PH_BODY) begin
      if ($urandom_range(99) < 6) col = st_stop_temp + int'($urandom_range(1, 3));
      else col = st_stop_temp - int'($urandom_range(0, 25));
    end else begin
      col = int'($urandom_range(0, 1800)) - 550;
    end
    col = sat12(col);
    if ($urandom_range(99) < 4) col = int'(raw[11:0]);
    roll = $urandom_range(99);
    if (roll < 80) begin
      outl = int'($urandom_range(0, cfg_val[CFG_OUTLET_MAX_TEMP] + 550)) - 550;
    end else if (roll < 95) begin
      outl = cfg_val[CFG_OUTLET_MAX_TEMP] + int'($urandom_range(0, 6)) - 3;
    end else begin
      outl = int'(raw[23:12]);
    end
    case (st_phase)
      PH_SELF, PH_WSELF, PH_WHEAD: a2_pct = 12;
      PH_BODY: a2_pct = 15;
      default: a2_pct = 10;
    endcase
    return mk_item(m, col, outl, $urandom_range(99) < 20, $urandom_range(99) < a2_pct,
                   $urandom_range(99) < 20, $urandom_range(99) < 2, raw[40]);
  endfunction

  task automatic offer(rps_item_t it, bit fixed, status_t want);
    status_t got;
    while (!calm && $urandom_range(99) < 7) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= it.mode;
    s_tdata <= {3'b000, it.heads_already_taken, it.flood_alarm, it.level_alarm,
                it.alarm2_fired, it.alarm1_fired, it.outlet_temp, it.column_temp};
    do @(posedge clk); while (!s_tready);
    got = advance_still(it);
    awaited_status.push_back(fixed ? want : got);
  endtask

  task automatic apply_config();
    for (int i = 0; i < 8; i++) begin
      cfg_we <= 1'b1;
      cfg_index <= cfg_index_t'(i);
      cfg_data <= next_cfg[i][9:0];
      @(posedge clk);
      cfg_val[i] = next_cfg[i];
    end
    cfg_we <= 1'b0;
  endtask

  task automatic check_field(string what, int want, int seen);
    if (want != seen) begin
      mismatches++;
      if (mismatches <= 10)
        $display("%0t: %s expected %0d, got %0d", $realtime, what, want, seen);
    end
  endtask

  initial begin : stimulus
    rps_item_t it;
    status_t   none_typed;
    status_t   all_clear;
    int        made;
    none_typed = '0;
    all_clear = mk_status(PH_OFF, 0, 0, 0, END_NONE, 0, 0, 0, 0, 0);

    script[0]  = '{mk_item(MODE_TICK, 0, 0, 0, 0, 0, 0, 0), 1'b1, all_clear};
    script[1]  = '{mk_item(MODE_RETURN, 0, 0, 0, 0, 0, 0, 0), 1'b1, all_clear};
    script[2]  = '{mk_item(MODE_CONTINUE, 0, 0, 0, 0, 0, 0, 0), 1'b1, all_clear};
    script[3]  = '{mk_item(MODE_START, 0, 0, 0, 0, 0, 0, 0), 1'b1,
                   mk_status(PH_WARM, 1, 98, 0, END_NONE, 0, 0, 0, 0, 1)};
    script[4]  = '{mk_item(MODE_TICK, 700, 0, 0, 0, 0, 0, 0), 1'b0, none_typed};
    script[5]  = '{mk_item(MODE_TICK, 701, 0, 0, 0, 0, 0, 0), 1'b1,
                   mk_status(PH_SELF, 1, 40, 300, END_NONE, 0, 3, 30, 0, 1)};
    script[6]  = '{mk_item(MODE_CONTINUE, 0, 0, 0, 0, 0, 0, 0), 1'b0, none_typed};
    script[7]  = '{mk_item(MODE_TICK, 0, 0, 0, 1, 0, 0, 0), 1'b0, none_typed};
    // A stop for want of self-run, then the over-temperature check still opens the valve.
    script[8]  = '{mk_item(MODE_TICK, 0, 451, 1, 1, 0, 0, 0), 1'b0, none_typed};
    script[9]  = '{mk_item(MODE_START, 0, 0, 0, 0, 0, 0, 0), 1'b0, none_typed};
    script[10] = '{mk_item(MODE_TICK, 2047, -2048, 1, 0, 0, 0, 0), 1'b0, none_typed};
    script[11] = '{mk_item(MODE_TICK, 0, 0, 0, 1, 0, 0, 0), 1'b0, none_typed};
    script[12] = '{mk_item(MODE_CONTINUE, 0, 0, 0, 0, 0, 0, 0), 1'b0, none_typed};
    script[13] = '{mk_item(MODE_TICK, 0, 0, 0, 0, 1, 0, 0), 1'b0, none_typed};
    script[14] = '{mk_item(MODE_TICK, 0, 0, 0, 1, 0, 0, 0), 1'b0, none_typed};
    script[15] = '{mk_item(MODE_START, 0, 0, 0, 0, 0, 0, 1), 1'b0, none_typed};
    script[16] = '{mk_item(MODE_TICK, 2047, 0, 0, 0, 0, 0, 0), 1'b0, none_typed};
    script[17] = '{mk_item(MODE_TICK, 0, 0, 0, 1, 0, 0, 0), 1'b0, none_typed};
    // The stop temperature saturates at the top of the signed range.
    script[18] = '{mk_item(MODE_CONTINUE, 2047, 0, 0, 0, 0, 0, 0), 1'b0, none_typed};
    script[19] = '{mk_item(MODE_TICK, 2047, 0, 0, 1, 0, 0, 0), 1'b0, none_typed};
    // Over-temperature, critical fault and flood in one tick: the critical stop
    // disarms the flood sensor first, so the fault stands.
    script[20] = '{mk_item(MODE_TICK, 0, 2047, 1, 0, 0, 1, 0), 1'b1,
                   mk_status(PH_OFF, 0, 0, 0, END_FAULT, 2047, 3, 0, 0, 0)};
    script[21] = '{mk_item(MODE_START, 0, 0, 0, 0, 0, 0, 1), 1'b0, none_typed};
    script[22] = '{mk_item(MODE_TICK, 701, 0, 0, 0, 0, 0, 0), 1'b0, none_typed};
    script[23] = '{mk_item(MODE_TICK, 0, 0, 0, 1, 0, 0, 0), 1'b0, none_typed};
    script[24] = '{mk_item(MODE_CONTINUE, -2048, 0, 0, 0, 0, 0, 0), 1'b0, none_typed};
    script[25] = '{mk_item(MODE_TICK, -2048, 451, 1, 0, 0, 0, 0), 1'b0, none_typed};
    script[26] = '{mk_item(MODE_RETURN, 0, 0, 0, 0, 0, 0, 0), 1'b0, none_typed};

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    foreach (script[i]) offer(script[i].item, script[i].fixed, script[i].want);

    for (int p = 0; p < RandomPhases; p++) begin
      s_tvalid <= 1'b0;
      while (awaited_status.size() != 0) @(posedge clk);
      repeat (4) @(posedge clk);
      case (p)
        0: next_cfg = '{20, 150, 10, 150, 10, 5, 0, 0};
        1: next_cfg = '{127, 1023, 127, 1023, 127, 127, 1023, 1023};
        2: next_cfg = '{100, 800, 100, 800, 100, 100, 1000, 1000};
        3, 4: next_cfg = '{$urandom_range(20, 100), $urandom_range(150, 800),
                           $urandom_range(10, 100), $urandom_range(150, 800),
                           $urandom_range(10, 100), $urandom_range(5, 100),
                           $urandom_range(0, 1000), $urandom_range(0, 1000)};
        default: next_cfg = '{40, 300, 60, 400, 70, 30, 450, 600};
      endcase
      apply_config();
      calm = (p == 2);
      made = 0;
      while (made < ItemsPerPhase) begin
        it = draw_item();
        if (st_phase != PH_OFF || it.mode == MODE_START) made++;
        if (p == 1 && made == 60) squeeze = 1'b1;
        offer(it, 1'b0, none_typed);
      end
    end
    s_tvalid <= 1'b0;
    calm = 1'b0;

    for (int k = 0; k < 2000 && awaited_status.size() != 0; k++) @(posedge clk);
    repeat (8) @(posedge clk);
    if (awaited_status.size() != 0) begin
      mismatches += awaited_status.size();
      $display("%0d results never arrived", awaited_status.size());
    end
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin : result_side
    int      hold_left;
    bit      held;
    status_t want;
    status_t seen;
    hold_left = 0;
    held = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && m_tvalid && m_tready) begin
        seen.process_state = phase_t'(m_tdata[2:0]);
        seen.heater_on = m_tdata[3];
        seen.heater_power = m_tdata[10:4];
        seen.valve_opening = m_tdata[20:11];
        seen.halt_cause = halt_cause_t'(m_tdata[23:21]);
        seen.stop_temp = m_tdata[35:24];
        seen.alarm1_request = m_tdata[37:36];
        seen.alarm2_request = m_tdata[44:38];
        seen.level_armed = m_tdata[45];
        seen.flood_armed = m_tdata[46];
        if (awaited_status.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("%0t: result with no item behind it", $realtime);
        end else begin
          want = awaited_status.pop_front();
          check_field("process_state", int'(want.process_state), int'(seen.process_state));
          check_field("heater_on", want.heater_on, seen.heater_on);
          check_field("heater_power", want.heater_power, seen.heater_power);
          check_field("valve_opening", want.valve_opening, seen.valve_opening);
          check_field("halt_cause", int'(want.halt_cause), int'(seen.halt_cause));
          check_field("stop_temp", want.stop_temp, seen.stop_temp);
          check_field("alarm1_request", want.alarm1_request, seen.alarm1_request);
          check_field("alarm2_request", want.alarm2_request, seen.alarm2_request);
          check_field("level_armed", want.level_armed, seen.level_armed);
          check_field("flood_armed", want.flood_armed, seen.flood_armed);
        end
      end
      // One long hold-off lets the unit fill up and push back on its input.
      if (squeeze && !held) begin
        held = 1'b1;
        hold_left = HoldOffCycles;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= calm || ($urandom_range(99) >= 7);
      end
    end
  end

  initial begin : watchdog
    #400_000;
    $display("FAILURE");
    $finish;
  end

endmodule

// File: sim.f
sv/rps_pkg.sv
sv/rps_cfg_regs.sv
sv/rps_step.sv
sv/rectification_process_sequencer_unit.sv
sv/rps_checker.sv
test/tb_rectification_process_sequencer_unit.sv
